/* sv/sxfb_pkg.sv */
// ----------------------------------------------------------------------------
// sxfb_pkg
// Shared constants and types for the sum/xor frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sxfb_pkg;

  localparam logic [7:0] START_BYTE = 8'hFE;
  localparam logic [7:0] END_BYTE   = 8'hFF;

  // Most bytes one item can produce: header (4) + data + trailer (3).
  localparam int MAX_BYTES = 8;
  localparam int REM_W     = $clog2(MAX_BYTES);

  // Frame tracking state carried between items.
  typedef struct packed {
    logic       in_frame;
    logic [7:0] bytes_left;
    logic [7:0] chk_sum;
    logic [7:0] chk_xor;
  } frame_state_t;

  // Burst of output bytes for one item; bytes[0] goes out first.
  // rem is the byte count minus one; closes marks a burst ending in END_BYTE.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [REM_W-1:0]          rem;
    logic                      closes;
  } burst_t;

endpackage

`default_nettype wire

/* sv/sxfb_burst_gen.sv */
// ----------------------------------------------------------------------------
// sxfb_burst_gen
// Builds the byte burst for one input word and the next frame state.
// ----------------------------------------------------------------------------
`default_nettype none

module sxfb_burst_gen (
  input  var sxfb_pkg::frame_state_t state_i,
  input  wire logic [7:0]            frame_type_i,
  input  wire logic [7:0]            frame_command_i,
  input  wire logic [7:0]            payload_length_i,
  input  wire logic [7:0]            data_byte_i,
  output sxfb_pkg::burst_t           burst_o,
  output sxfb_pkg::frame_state_t     state_o
);

  logic [7:0] hdr_sum;
  logic [7:0] hdr_xor;
  logic [7:0] dat_sum;
  logic [7:0] dat_xor;
  logic [7:0] left_dec;

  always_comb begin
    hdr_sum  = frame_type_i + frame_command_i + payload_length_i;
    hdr_xor  = frame_type_i ^ frame_command_i ^ payload_length_i;
    dat_sum  = (state_i.in_frame ? state_i.chk_sum : hdr_sum) + data_byte_i;
    dat_xor  = (state_i.in_frame ? state_i.chk_xor : hdr_xor) ^ data_byte_i;
    left_dec = (state_i.in_frame ? state_i.bytes_left : payload_length_i) - 8'd1;

    burst_o = '0;
    state_o = '0;

    if (!state_i.in_frame) begin
      burst_o.bytes[0] = sxfb_pkg::START_BYTE;
      burst_o.bytes[1] = frame_type_i;
      burst_o.bytes[2] = frame_command_i;
      burst_o.bytes[3] = payload_length_i;
      if (payload_length_i == 8'd0) begin
        // empty payload: header then trailer, stay idle
        burst_o.bytes[4] = hdr_sum;
        burst_o.bytes[5] = hdr_xor;
        burst_o.bytes[6] = sxfb_pkg::END_BYTE;
        burst_o.rem      = sxfb_pkg::REM_W'(6);
        burst_o.closes   = 1'b1;
      end else begin
        burst_o.bytes[4] = data_byte_i;
        if (left_dec == 8'd0) begin
          burst_o.bytes[5] = dat_sum;
          burst_o.bytes[6] = dat_xor;
          burst_o.bytes[7] = sxfb_pkg::END_BYTE;
          burst_o.rem      = sxfb_pkg::REM_W'(7);
          burst_o.closes   = 1'b1;
        end else begin
          burst_o.rem        = sxfb_pkg::REM_W'(4);
          state_o.in_frame   = 1'b1;
          state_o.bytes_left = left_dec;
          state_o.chk_sum    = dat_sum;
          state_o.chk_xor    = dat_xor;
        end
      end
    end else begin
      burst_o.bytes[0] = data_byte_i;
      if (left_dec == 8'd0) begin
        burst_o.bytes[1] = dat_sum;
        burst_o.bytes[2] = dat_xor;
        burst_o.bytes[3] = sxfb_pkg::END_BYTE;
        burst_o.rem      = sxfb_pkg::REM_W'(3);
        burst_o.closes   = 1'b1;
      end else begin
        burst_o.rem        = sxfb_pkg::REM_W'(0);
        state_o.in_frame   = 1'b1;
        state_o.bytes_left = left_dec;
        state_o.chk_sum    = dat_sum;
        state_o.chk_xor    = dat_xor;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/sum_xor_frame_builder_top.sv */
// ----------------------------------------------------------------------------
// sum_xor_frame_builder_top
// Byte frame builder: FE, type, cmd, len, payload, sum, xor, FF.
// ----------------------------------------------------------------------------
// Path: a word's burst goes from the burst register to the output shifter,
//   whose byte 0 is on the port, once the shifter is free.
// Throughput: while out_stall_i is low, one output byte per cycle; a word's
//   burst holds 1, 4, 5, 7 or 8 bytes, so payload words stream one per cycle.
// Reset: async active low; clears frame state and both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module sum_xor_frame_builder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input channel
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] frame_type_i,
  input  wire logic [7:0] frame_command_i,
  input  wire logic [7:0] payload_length_i,
  input  wire logic [7:0] data_byte_i,
  // output channel
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            run_last_o,
  output logic            frame_done_o
);

  // Frame state: updated the cycle a word is accepted, so the next word
  // can be taken right behind it.
  sxfb_pkg::frame_state_t state_q, state_d;

  // Burst register: one fully built burst waiting for the shifter.
  sxfb_pkg::burst_t pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;

  // Output shifter: current burst, byte 0 on the port.
  sxfb_pkg::burst_t ser_q, ser_d;
  logic             ser_valid_q, ser_valid_d;

  logic in_acc;
  logic ser_take;
  logic ser_done;
  logic ser_free;
  logic pend_move;

  sxfb_burst_gen u_burst_gen (
    .state_i          (state_q),
    .frame_type_i     (frame_type_i),
    .frame_command_i  (frame_command_i),
    .payload_length_i (payload_length_i),
    .data_byte_i      (data_byte_i),
    .burst_o          (pend_d),
    .state_o          (state_d)
  );

  // Handshake plumbing. The shifter frees up on the cycle its last byte is
  // taken, so the waiting burst moves in without a bubble.
  assign ser_take  = ser_valid_q && !out_stall_i;
  assign ser_done  = ser_take && (ser_q.rem == '0);
  assign ser_free  = !ser_valid_q || ser_done;
  assign pend_move = pend_valid_q && ser_free;
  assign in_stall_o = pend_valid_q && !ser_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign pend_valid_d = in_acc || (pend_valid_q && !pend_move);
  assign ser_valid_d  = pend_move || (ser_valid_q && !ser_done);

  always_comb begin
    ser_d = ser_q;
    if (pend_move) begin
      ser_d = pend_q;
    end else if (ser_take) begin
      ser_d.bytes = {8'h00, ser_q.bytes[sxfb_pkg::MAX_BYTES-1:1]};
      ser_d.rem   = ser_q.rem - sxfb_pkg::REM_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      pend_valid_q <= 1'b0;
      ser_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      pend_valid_q <= pend_valid_d;
      ser_valid_q  <= ser_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pend_q <= pend_d;
    end
    ser_q <= ser_d;
  end

  assign out_valid_o  = ser_valid_q;
  assign out_byte_o   = ser_q.bytes[0];
  assign run_last_o   = (ser_q.rem == '0);
  assign frame_done_o = ser_q.closes && (ser_q.rem == '0);

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Input only backs up behind a full burst register.
  a_stall_needs_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pend_valid_q)
    else $error("input stalled with empty burst register");

  // The closing byte always ends the word's burst.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> run_last_o)
    else $error("frame end not on last byte of burst");

  // An open frame always expects more payload.
  a_open_frame_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_frame |-> (state_q.bytes_left != 8'd0))
    else $error("open frame with no bytes left");

  // A burst that reached the shifter came from the burst register.
  a_ser_from_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ser_valid_q) |-> $past(pend_valid_q))
    else $error("shifter loaded without a pending burst");

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sum_xor_frame_builder_top. A driver pushes input
// words from a queue and a predictor turns every accepted word into the
// frame bytes it must produce. A monitor checks each output byte against
// the oldest predicted byte.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 180;
  localparam int LONG_AT_WORD = 60;   // long frame starts after this many random words
  localparam int LONG_LEN     = 120;
  localparam int HOLD_AT_WORD = 60;   // receiver hold-off starts after this many words
  localparam int HOLD_CYCLES  = 400;
  localparam int TAIL_CYCLES  = 20;   // quiet time after the last byte

  // One input word plus how the driver should present it.
  typedef struct {
    logic [7:0] frame_type;
    logic [7:0] frame_command;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
    int         idle_gap;     // cycles with valid low before this word
    bit         drain_first;  // hold the word until all bytes are out
  } word_t;

  // One output byte as predicted.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
    logic       done;
  } frame_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_type = 8'h00;
  logic [7:0] in_cmd = 8'h00;
  logic [7:0] in_len = 8'h00;
  logic [7:0] in_data = 8'h00;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_done;

  sum_xor_frame_builder_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .frame_type_i     (in_type),
    .frame_command_i  (in_cmd),
    .payload_length_i (in_len),
    .data_byte_i      (in_data),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_byte_o       (out_byte),
    .run_last_o       (out_last),
    .frame_done_o     (out_done)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Frame predictor: its own copy of the frame state.
  // --------------------------------------------------------------------------
  logic        open_frame = 1'b0;
  logic [7:0]  left_count = 8'h00;
  logic [7:0]  sum_acc = 8'h00;
  logic [7:0]  xor_acc = 8'h00;
  frame_byte_t burst_buf [sxfb_pkg::MAX_BYTES];
  int          burst_n;
  frame_byte_t expected_bytes [$];

  function automatic void put_raw(logic [7:0] b, logic done);
    burst_buf[burst_n] = '{value: b, last: 1'b0, done: done};
    burst_n++;
  endfunction

  // Bytes from type through the last payload byte feed both checksums.
  function automatic void put_checked(logic [7:0] b);
    sum_acc = sum_acc + b;
    xor_acc = xor_acc ^ b;
    put_raw(b, 1'b0);
  endfunction

  function automatic void put_trailer();
    put_raw(sum_acc, 1'b0);
    put_raw(xor_acc, 1'b0);
    put_raw(sxfb_pkg::END_BYTE, 1'b1);
    open_frame = 1'b0;
    left_count = 8'h00;
    sum_acc    = 8'h00;
    xor_acc    = 8'h00;
  endfunction

  function automatic void predict_frame_bytes(word_t w);
    burst_n = 0;
    if (!open_frame) begin
      sum_acc = 8'h00;
      xor_acc = 8'h00;
      put_raw(sxfb_pkg::START_BYTE, 1'b0);
      put_checked(w.frame_type);
      put_checked(w.frame_command);
      put_checked(w.payload_length);
      if (w.payload_length == 8'h00) begin
        // empty payload: data byte is dropped, straight to the trailer
        put_trailer();
      end else begin
        put_checked(w.data_byte);
        left_count = w.payload_length - 8'd1;
        if (left_count == 8'h00) put_trailer();
        else open_frame = 1'b1;
      end
    end else begin
      // mid-frame word: only the data byte matters
      put_checked(w.data_byte);
      left_count = left_count - 8'd1;
      if (left_count == 8'h00) put_trailer();
    end
    burst_buf[burst_n-1].last = 1'b1;
    for (int i = 0; i < burst_n; i++) expected_bytes.push_back(burst_buf[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  word_t pending_words [$];
  bit    quiet_sender = 1'b0;  // when set, words go back to back

  function automatic int draw_gap();
    return quiet_sender ? 0 : $urandom_range(0, 9);
  endfunction

  // Queue a whole frame. fill < 0 gives random payload after the first byte.
  // Header fields on mid-frame words are random noise the block must ignore.
  function automatic void queue_frame(logic [7:0] ftype, logic [7:0] fcmd,
                                      logic [7:0] flen, logic [7:0] first_data,
                                      int fill, bit drain);
    word_t w;
    w.frame_type     = ftype;
    w.frame_command  = fcmd;
    w.payload_length = flen;
    w.data_byte      = first_data;
    w.idle_gap       = draw_gap();
    w.drain_first    = drain;
    pending_words.push_back(w);
    for (int i = 1; i < flen; i++) begin
      w.frame_type     = 8'($urandom_range(0, 255));
      w.frame_command  = 8'($urandom_range(0, 255));
      w.payload_length = 8'($urandom_range(0, 255));
      w.data_byte      = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      w.idle_gap       = draw_gap();
      w.drain_first    = 1'b0;
      pending_words.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  word_t cur_word;
  bit    loaded = 1'b0;
  bit    send;
  int    idle_left = 0;
  int    words_in = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_frame_bytes(cur_word);
        words_in++;
        loaded = 1'b0;
      end
      if (!loaded && pending_words.size() > 0) begin
        cur_word  = pending_words.pop_front();
        loaded    = 1'b1;
        idle_left = cur_word.idle_gap;
      end
      send = 1'b0;
      if (loaded) begin
        if (in_valid && in_stall) send = 1'b1;  // stalled word stays put
        else if (idle_left > 0) idle_left--;
        else if (!cur_word.drain_first || expected_bytes.size() == 0) send = 1'b1;
      end
      in_valid <= send;
      if (send) begin
        in_type <= cur_word.frame_type;
        in_cmd  <= cur_word.frame_command;
        in_len  <= cur_word.payload_length;
        in_data <= cur_word.data_byte;
      end else begin
        // idle bus carries junk
        in_type <= 8'($urandom_range(0, 255));
        in_cmd  <= 8'($urandom_range(0, 255));
        in_len  <= 8'($urandom_range(0, 255));
        in_data <= 8'($urandom_range(0, 255));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall per byte, calm stretches, one long hold-off.
  // --------------------------------------------------------------------------
  int cycle_count = 0;
  int rx_wait = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && words_in >= HOLD_AT_WORD) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        // block backs up and must push back on its input
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (out_valid && !out_stall)
          rx_wait = ((cycle_count % 700) < 200) ? 0 : $urandom_range(0, 9);
        else if (rx_wait > 0)
          rx_wait--;
        out_stall <= (rx_wait > 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and checker
  // --------------------------------------------------------------------------
  int          error_count = 0;
  frame_byte_t exp_b;

  task automatic report_mismatch(string what, frame_byte_t want);
    error_count++;
    if (error_count <= 10)
      $display("[%0t] mismatch (%s): expected byte %h last %b done %b, got byte %h last %b done %b",
               $realtime, what, want.value, want.last, want.done,
               out_byte, out_last, out_done);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("no byte expected", '0);
      end else begin
        exp_b = expected_bytes.pop_front();
        if (out_byte !== exp_b.value || out_last !== exp_b.last ||
            out_done !== exp_b.done)
          report_mismatch("wrong field", exp_b);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d bytes still expected", expected_bytes.size());
      $display("** sum_xor_frame_builder_top: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  int  random_words;
  int  flen;
  int  frame_idx;
  bit  big_done;

  initial begin
    // directed: empty payloads, single bytes, all-ones sums that wrap
    queue_frame(8'hFF, 8'hFF, 8'd0, 8'hAA, -1, 1'b0);
    queue_frame(8'h00, 8'h00, 8'd0, 8'h55, -1, 1'b0);
    queue_frame(8'h12, 8'h34, 8'd1, 8'h00, -1, 1'b0);
    queue_frame(8'hFF, 8'hFF, 8'd1, 8'hFF, -1, 1'b0);
    queue_frame(8'h5A, 8'hA5, 8'd2, 8'h3C, -1, 1'b0);
    queue_frame(8'h80, 8'h01, 8'd3, 8'h7F, -1, 1'b0);
    queue_frame(8'h7F, 8'hFE, 8'd8, 8'hFF, 8'hFF, 1'b0);
    queue_frame(8'h00, 8'hFF, 8'd1, 8'h01, -1, 1'b0);

    // random frames, mostly short; one long frame in the middle
    random_words = 0;
    frame_idx    = 0;
    big_done     = 1'b0;
    while (random_words < RANDOM_WORDS) begin
      quiet_sender = (frame_idx % 6 == 5);
      if (!big_done && random_words >= LONG_AT_WORD) begin
        flen     = LONG_LEN;
        big_done = 1'b1;
      end else begin
        case ($urandom_range(0, 4))
          0:       flen = 0;
          1:       flen = 1;
          default: flen = $urandom_range(2, 8);
        endcase
      end
      // the sender waits for a drained output before the first random frame
      // and before the long one
      queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'(flen),
                  8'($urandom_range(0, 255)), -1, (frame_idx == 0) || (flen == LONG_LEN));
      random_words += (flen == 0) ? 1 : flen;
      frame_idx++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (loaded || pending_words.size() > 0) @(posedge clk);
    while (expected_bytes.size() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("** sum_xor_frame_builder_top: PASSED **");
    end else begin
      $display("%0d mismatches", error_count);
      $display("** sum_xor_frame_builder_top: FAILED **");
    end
    $finish;
  end

endmodule
